// ----- hw/rtl/key_matrix_scan_debounce_core_macros.svh -----
// Assertion macros shared by the key matrix debounce checker.
`ifndef KEY_MATRIX_SCAN_DEBOUNCE_CORE_MACROS_SVH
`define KEY_MATRIX_SCAN_DEBOUNCE_CORE_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define KMSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define KMSD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/kmsd_pkg.sv -----
// Types and constants for the key matrix scan debounce block.
package kmsd_pkg;

  localparam int ROW_COUNT    = 5;
  localparam int COLUMN_COUNT = 14;
  localparam int ROW_IDX_W    = 3;
  localparam int SETTLE_W     = 8;

  localparam logic [SETTLE_W-1:0]  SETTLE_RESET = SETTLE_W'(5);
  localparam logic [ROW_IDX_W-1:0] ROW_LIMIT    = ROW_IDX_W'(ROW_COUNT);
  localparam logic [ROW_IDX_W-1:0] LAST_ROW     = ROW_IDX_W'(ROW_COUNT - 1);

  typedef struct packed {
    logic [ROW_IDX_W-1:0]    row_index;
    logic [COLUMN_COUNT-1:0] column_bits;
  } in_item_t;

  typedef struct packed {
    logic [COLUMN_COUNT-1:0] stable_row;
    logic                    settling;
    logic                    committed;
  } out_item_t;

endpackage

// ----- hw/rtl/kmsd_out_buf.sv -----
// Two-entry result buffer: output register plus skid register.
module kmsd_out_buf import kmsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  out_item_t push_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_item_r, main_item_nxt;
  out_item_t skid_item_r, skid_item_nxt;
  logic      push;

  assign push_ready = !skid_valid_r;
  assign push       = push_valid && push_ready;
  assign out_valid  = main_valid_r;
  assign out_item   = main_item_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_item_nxt  = main_item_r;
    skid_item_nxt  = skid_item_r;
    if (!main_valid_r || out_ready) begin
      // main slot frees up: refill from skid first, else from the new transaction
      if (skid_valid_r) begin
        main_item_nxt  = skid_item_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_item_nxt  = push_item;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_item_nxt  = push_item;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_item_r <= main_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

endmodule

// ----- hw/rtl/key_matrix_scan_debounce_core.sv -----
// Global-settle debouncer for a split key matrix, one row sample per transaction.
//
// Each input transaction carries one sampled row (row_index, 14 column bits: the
// local half in bits 0-6, the remote half in bits 7-13). A sample that differs from
// the stored raw row replaces it and reloads the shared settle counter from the
// settle_scans register. The sample of the last row ends a scan: a nonzero counter
// then counts down, and when it reaches zero all raw rows are copied into the stable
// matrix in that same cycle. Every input transaction yields exactly one result
// (stable_row of the addressed row, settling, committed); a row index past the last
// row changes nothing and returns stable_row 0. Throughput is one transaction per
// clock while in_ready is high: compare, counter update and commit are combinational
// logic feeding the state and the output buffer, and each result is registered
// there before out_valid offers it. A two-deep output buffer (result register plus
// skid register) keeps in_ready high while one result waits, so in_ready drops only
// when two results are held. settle_scans resets to 5 and is written through the cfg
// port, which is always ready; a write takes effect at the next counter reload.
module key_matrix_scan_debounce_core import kmsd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SETTLE_W-1:0] cfg_data
);

  // Matrix state and settle counter.
  logic [COLUMN_COUNT-1:0] raw_rows_r    [ROW_COUNT];
  logic [COLUMN_COUNT-1:0] stable_rows_r [ROW_COUNT];
  logic [SETTLE_W-1:0]     settle_scans_r;
  logic [SETTLE_W-1:0]     settle_count_r, settle_count_nxt;

  logic                    accept;
  logic                    row_ok;
  logic                    changed;
  logic                    scan_end;
  logic                    commit;
  logic [SETTLE_W-1:0]     count_loaded;
  logic [ROW_IDX_W-1:0]    sel;
  logic [COLUMN_COUNT-1:0] sample;
  out_item_t               result;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign sel       = in_item.row_index;
  assign sample    = in_item.column_bits;
  assign row_ok    = (sel < ROW_LIMIT);

  always_comb begin
    // compare against the stored raw row; a change reloads the counter
    changed      = row_ok && (raw_rows_r[sel] != sample);
    count_loaded = changed ? settle_scans_r : settle_count_r;
    // last row closes a scan: count down a busy counter
    scan_end     = row_ok && (sel == LAST_ROW) && (count_loaded != '0);
    commit       = scan_end && (count_loaded == SETTLE_W'(1));
    settle_count_nxt = scan_end ? (count_loaded - SETTLE_W'(1)) : count_loaded;

    result.settling  = (settle_count_nxt != '0);
    result.committed = commit;
    if (!row_ok) begin
      result.stable_row = '0;
    end else if (commit) begin
      // stable row of this index becomes the new sample on commit
      result.stable_row = sample;
    end else begin
      result.stable_row = stable_rows_r[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_scans_r <= SETTLE_RESET;
      settle_count_r <= SETTLE_RESET;
      for (int r = 0; r < ROW_COUNT; r++) begin
        raw_rows_r[r]    <= '0;
        stable_rows_r[r] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        settle_scans_r <= cfg_data;
      end
      if (accept) begin
        settle_count_r <= settle_count_nxt;
        if (changed) begin
          raw_rows_r[sel] <= sample;
        end
        if (commit) begin
          // copy the whole raw matrix, with this transaction's sample in place
          for (int r = 0; r < ROW_COUNT; r++) begin
            if (sel == ROW_IDX_W'(r)) begin
              stable_rows_r[r] <= sample;
            end else begin
              stable_rows_r[r] <= raw_rows_r[r];
            end
          end
        end
      end
    end
  end

  // Result register with skid: holds up to two results under backpressure.
  kmsd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ----- hw/rtl/kmsd_checker.sv -----
// Port-level checks for the key matrix debounce core, bound to the top level.
`include "key_matrix_scan_debounce_core_macros.svh"

module kmsd_checker import kmsd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // a waiting result holds steady
  `KMSD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_item), "result changed while stalled")
  // a commit always leaves the counter idle
  `KMSD_ASSERT(a_commit_idle, clk, rst_n, out_valid && out_item.committed |-> !out_item.settling, "commit reported while settling")
  // input stalls only while results are pending
  `KMSD_ASSERT(a_stall_pending, clk, rst_n, !in_ready |-> out_valid, "input stalled with no result pending")
  // a transaction into an empty output shows a result next cycle
  `KMSD_ASSERT(a_result_next, clk, rst_n, in_valid && in_ready && !out_valid |=> out_valid, "result missing after transaction")
  // reset drops any pending result
  `KMSD_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind key_matrix_scan_debounce_core kmsd_checker u_kmsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ----- tb/key_matrix_scan_debounce_core_tb.sv -----
// Self-checking testbench for the key matrix scan debounce core.
`timescale 1ns / 1ps

module key_matrix_scan_debounce_core_tb import kmsd_pkg::*; ();

  // Tracks the raw and stable matrices and the settle counter, and queues the
  // result each accepted row sample should produce.
  class debounce_scoreboard;
    logic [COLUMN_COUNT-1:0] raw_matrix [ROW_COUNT];
    logic [COLUMN_COUNT-1:0] stable_matrix [ROW_COUNT];
    logic [SETTLE_W-1:0]     settle_left;
    logic [SETTLE_W-1:0]     settle_reload;
    out_item_t               expected_rows [$];
    int                      errors;
    int                      commits;
    int                      results;

    function new();
      for (int r = 0; r < ROW_COUNT; r++) begin
        raw_matrix[r]    = '0;
        stable_matrix[r] = '0;
      end
      settle_left   = SETTLE_RESET;
      settle_reload = SETTLE_RESET;
      errors        = 0;
      commits       = 0;
      results       = 0;
    endfunction

    function void set_reload(input logic [SETTLE_W-1:0] value);
      settle_reload = value;
    endfunction

    function void note_row_sample(input in_item_t sample);
      out_item_t res;
      int        idx;
      res = '0;
      if (sample.row_index < ROW_LIMIT) begin
        idx = int'(sample.row_index);
        if (raw_matrix[idx] != sample.column_bits) begin
          raw_matrix[idx] = sample.column_bits;
          settle_left     = settle_reload;
        end
        if (sample.row_index == LAST_ROW && settle_left != '0) begin
          settle_left = settle_left - 1'b1;
          if (settle_left == '0) begin
            for (int r = 0; r < ROW_COUNT; r++) stable_matrix[r] = raw_matrix[r];
            res.committed = 1'b1;
          end
        end
        res.stable_row = stable_matrix[idx];
      end
      res.settling = (settle_left != '0);
      expected_rows.push_back(res);
    endfunction

    function void check_row_result(input out_item_t got);
      out_item_t want;
      results++;
      if (expected_rows.size() == 0) begin
        $error("result with no pending expectation: %h", got);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      if (want.committed) commits++;
      if (got.stable_row !== want.stable_row) begin
        $error("stable_row expected %h actual %h", want.stable_row, got.stable_row);
        errors++;
      end
      if (got.settling !== want.settling) begin
        $error("settling expected %b actual %b", want.settling, got.settling);
        errors++;
      end
      if (got.committed !== want.committed) begin
        $error("committed expected %b actual %b", want.committed, got.committed);
        errors++;
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [SETTLE_W-1:0] cfg_data  = '0;

  debounce_scoreboard sb = new();

  // Shared pacing controls: calm turns off idling on both sides, hold_request
  // asks the receiver for one long hold-off.
  bit calm         = 1'b0;
  bit hold_request = 1'b0;
  int settings_written = 0;

  // Key pattern each row is meant to show; scans mostly repeat it.
  logic [COLUMN_COUNT-1:0] pressed_keys [ROW_COUNT];

  key_matrix_scan_debounce_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Sample both handshakes on the edge that completes them; values seen here
  // are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_row_result(out_item);
    if (rst_n && in_valid && in_ready) sb.note_row_sample(in_item);
  end

  // Receiver: random back-pressure, none while calm, and one long hold-off
  // on request so the output buffer fills and in_ready drops.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 300;
        out_ready    <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 38);
      end
    end
  end

  // Offer one row sample and return on the edge that accepts it, leaving
  // in_valid high so a back-to-back transaction needs no extra edge.
  task automatic send_row(input in_item_t sample);
    bit seen;
    if (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    in_valid <= 1'b1;
    in_item  <= sample;
    do begin
      @(negedge clk);
      seen = in_ready;
      @(posedge clk);
    end while (!seen);
  endtask

  task automatic send_fields(input int row, input logic [COLUMN_COUNT-1:0] bits);
    in_item_t sample;
    sample.row_index   = ROW_IDX_W'(row);
    sample.column_bits = bits;
    send_row(sample);
  endtask

  // Drop valid and hold until every queued result has been checked.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write settle_scans; only called with the block idle.
  task automatic write_settle(input logic [SETTLE_W-1:0] value);
    bit seen;
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      seen = cfg_ready;
      @(posedge clk);
    end while (!seen);
    cfg_valid <= 1'b0;
    sb.set_reload(value);
    settings_written++;
  endtask

  // Mostly clean scans of rows 0..last with rare key changes, plus noise:
  // random row order and out-of-range indexes.
  task automatic run_scans(input int n_items);
    int                      sent;
    logic [COLUMN_COUNT-1:0] flip;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        for (int r = 0; r < ROW_COUNT; r++) begin
          if ($urandom_range(99) < 5) begin
            flip = $urandom_range(1) ? COLUMN_COUNT'(1) << $urandom_range(COLUMN_COUNT - 1)
                                     : COLUMN_COUNT'($urandom);
            pressed_keys[r] = pressed_keys[r] ^ flip;
          end
          send_fields(r, pressed_keys[r]);
          sent++;
        end
      end else begin
        send_fields($urandom_range(7), COLUMN_COUNT'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [SETTLE_W-1:0] phase_settle [8];
    phase_settle = '{SETTLE_W'(5), SETTLE_W'(1), SETTLE_W'(3), SETTLE_W'(255),
                     SETTLE_W'(2), SETTLE_W'(0), SETTLE_W'(1), SETTLE_W'(4)};
    for (int r = 0; r < ROW_COUNT; r++) pressed_keys[r] = COLUMN_COUNT'($urandom);

    // Hold reset, then release it once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset setting, field extremes and indexes past the last row.
    send_fields(0, 14'h3FFF);
    send_fields(1, 14'h007F);
    send_fields(2, 14'h3F80);
    send_fields(3, 14'h0000);
    send_fields(4, 14'h2AAA);
    send_fields(5, 14'h3FFF);
    send_fields(6, 14'h1555);
    send_fields(7, 14'h3FFF);
    drain_results();

    // Shortest settle: one change, then commit at the end of the same scan.
    write_settle(SETTLE_W'(1));
    send_fields(0, 14'h1555);
    send_fields(1, 14'h007F);
    send_fields(2, 14'h3F80);
    send_fields(3, 14'h0000);
    send_fields(4, 14'h2AAA);
    // Counter already zero at scan end: nothing commits.
    send_fields(4, 14'h2AAA);
    drain_results();

    // Zero reload: the change parks the counter and never commits.
    write_settle(SETTLE_W'(0));
    send_fields(2, 14'h3FFF);
    send_fields(4, 14'h2AAA);
    drain_results();

    // Register write leaves the counter alone until the next reload.
    write_settle(SETTLE_W'(255));
    send_fields(4, 14'h2AAA);
    send_fields(3, 14'h3FFF);
    send_fields(4, 14'h2AAA);
    drain_results();

    // Random phases across several settle settings.
    for (int p = 0; p < 8; p++) begin
      write_settle(p == 7 ? SETTLE_W'($urandom_range(2, 8)) : phase_settle[p]);
      calm = (p == 2);
      if (p == 3) hold_request = 1'b1;
      run_scans(190);
      drain_results();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk);
    $display("checked %0d row results, %0d commits, over %0d settle_scans settings",
             sb.results, sb.commits, settings_written);
    $display("included out-of-range rows, zero reload, long output stall and calm stretch");
    if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
